[rtl/enhanced_clock_victim_select_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the clock victim selector
// Shared immediate-style wrappers around concurrent properties.
// ---------------------------------------------------------------------------
`ifndef ENHANCED_CLOCK_VICTIM_SELECT_MACROS_SVH
`define ENHANCED_CLOCK_VICTIM_SELECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ECVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ecvs_pkg.sv]
// ---------------------------------------------------------------------------
// ecvs_pkg
// Widths, codes and controller/datapath interface types of the selector.
// ---------------------------------------------------------------------------
`default_nettype none

package ecvs_pkg;

  localparam int FRAME_W        = 6;
  localparam int COUNT_W        = 7;
  localparam int MAX_FRAMES_DEF = 64;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 7'd64;

  // Request codes on the action field
  localparam logic ACT_REF    = 1'b0;
  localparam logic ACT_VICTIM = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;     // zero one entry of the bit memories, advance sweep
    logic ref_wr;       // take a reference request, post an empty result
    logic vic_start;    // take a victim request, aim the scan at the hand
    logic scan_step;    // issue the next read of the scan
    logic pass2_start;  // restart the scan at the start frame
    logic clear_use;    // drop the use bit of the frame just read
    logic latch_victim; // hold the frame just read as the victim
    logic finish;       // retire the victim, move the hand, post the result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;     // sweep is at the last entry
    logic out_free;     // output register can take a result this cycle
    logic dv;           // read data belongs to the current scan
    logic cand_clean;   // read frame has use and modified bits clear
    logic cand_use;     // read frame has its use bit clear
    logic pass_end;     // read frame is the last of the first pass
  } stat_t;

endpackage

`default_nettype wire

[rtl/ecvs_ctrl.sv]
// ---------------------------------------------------------------------------
// ecvs_ctrl
// Sequencer for the clear sweep, references and the two victim passes.
// ---------------------------------------------------------------------------
`default_nettype none

module ecvs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          action,
  output logic               in_stall,
  input  wire ecvs_pkg::stat_t st,
  output ecvs_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && st.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ecvs_pkg::ACT_REF) begin
            cmd.ref_wr = 1'b1;
          end else begin
            cmd.vic_start = 1'b1;
            state_next    = S_PASS1;
          end
        end
      end
      S_PASS1: begin
        if (st.cand_clean) begin
          cmd.latch_victim = 1'b1;
          state_next       = S_FIN;
        end else if (st.pass_end) begin
          cmd.pass2_start = 1'b1;
          state_next      = S_PASS2;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_PASS2: begin
        if (st.cand_use) begin
          cmd.latch_victim = 1'b1;
          state_next       = S_FIN;
        end else begin
          cmd.scan_step = 1'b1;
          cmd.clear_use = st.dv;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ecvs_dp.sv]
// ---------------------------------------------------------------------------
// ecvs_dp
// Use/modified bit memories, clock hand, scan pointer and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "enhanced_clock_victim_select_macros.svh"

module ecvs_dp #(
  parameter int MAX_FRAMES = ecvs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ecvs_pkg::cmd_t                cmd,
  output ecvs_pkg::stat_t                    st,
  input  wire logic [ecvs_pkg::FRAME_W-1:0]  frame,
  input  wire logic                          is_write,
  input  wire logic                          cfg_we,
  input  wire logic [ecvs_pkg::COUNT_W-1:0]  cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               victim_valid,
  output logic [ecvs_pkg::FRAME_W-1:0]       victim_frame,
  output logic                               victim_dirty
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int CW = (NW > ecvs_pkg::COUNT_W) ? NW : ecvs_pkg::COUNT_W;
  localparam int WW = (NW > ecvs_pkg::FRAME_W) ? NW : ecvs_pkg::FRAME_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FRAMES - 1);

  // Bring a raw frame count into 1..MAX_FRAMES
  function automatic logic [NW-1:0] clamp_count(input logic [ecvs_pkg::COUNT_W-1:0] fc);
    logic [NW-1:0] r;
    if (fc == '0) begin
      r = NW'(1);
    end else if (CW'(fc) > CW'(MAX_FRAMES)) begin
      r = NW'(MAX_FRAMES);
    end else begin
      r = NW'(fc);
    end
    return r;
  endfunction

  logic            use_mem [MAX_FRAMES];
  logic            mod_mem [MAX_FRAMES];

  logic [NW-1:0]   n;
  logic [IW-1:0]   hand;
  logic [IW-1:0]   ptr;
  logic [IW-1:0]   start;
  logic [IW-1:0]   cur;
  logic [NW-1:0]   cnt;
  logic            dv;
  logic            use_q;
  logic            mod_q;
  logic            use_byp;
  logic            mod_byp;
  logic            use_bd;
  logic            mod_bd;
  logic [IW-1:0]   vic;
  logic            vic_dirty;

  logic            use_we;
  logic [IW-1:0]   use_wa;
  logic            use_wd;
  logic            mod_we;
  logic [IW-1:0]   mod_wa;
  logic            mod_wd;

  logic            rd_use;
  logic            rd_mod;
  logic            in_range;
  logic [IW-1:0]   start_next;
  logic [IW-1:0]   ptr_inc;
  logic [IW-1:0]   vic_inc;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] f, input logic [NW-1:0] cnt_n);
    logic [NW:0] s;
    s = (NW + 1)'(f) + (NW + 1)'(1);
    return (s >= (NW + 1)'(cnt_n)) ? '0 : IW'(s);
  endfunction

  assign rd_use     = use_byp ? use_bd : use_q;
  assign rd_mod     = mod_byp ? mod_bd : mod_q;
  assign in_range   = WW'(frame) < WW'(n);
  assign start_next = (NW'(hand) < n) ? hand : '0;
  assign ptr_inc    = next_idx(ptr, n);
  assign vic_inc    = next_idx(vic, n);

  assign st.clr_last   = (ptr == LAST_IDX);
  assign st.out_free   = !out_valid || !out_stall;
  assign st.dv         = dv;
  assign st.cand_clean = dv && !rd_use && !rd_mod;
  assign st.cand_use   = dv && !rd_use;
  assign st.pass_end   = dv && (cnt == n - NW'(1));

  // Write port selection: one write per memory per cycle
  always_comb begin
    use_we = 1'b0;
    use_wa = ptr;
    use_wd = 1'b0;
    mod_we = 1'b0;
    mod_wa = ptr;
    mod_wd = 1'b0;
    if (cmd.clr_step) begin
      use_we = 1'b1;
      mod_we = 1'b1;
    end else if (cmd.ref_wr) begin
      use_we = in_range;
      use_wa = IW'(frame);
      use_wd = 1'b1;
      mod_we = in_range && is_write;
      mod_wa = IW'(frame);
      mod_wd = 1'b1;
    end else if (cmd.clear_use) begin
      use_we = 1'b1;
      use_wa = cur;
    end else if (cmd.finish) begin
      use_we = 1'b1;
      use_wa = vic;
      mod_we = 1'b1;
      mod_wa = vic;
    end
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    if (mod_we) begin
      mod_mem[mod_wa] <= mod_wd;
    end
  end

  // Registered read at the scan pointer, with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    use_q   <= use_mem[ptr];
    mod_q   <= mod_mem[ptr];
    use_byp <= use_we && (use_wa == ptr);
    mod_byp <= mod_we && (mod_wa == ptr);
    use_bd  <= use_wd;
    mod_bd  <= mod_wd;
    cur     <= ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= clamp_count(ecvs_pkg::FRAME_COUNT_RST);
      hand      <= '0;
      ptr       <= '0;
      start     <= '0;
      cnt       <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        n <= clamp_count(cfg_data);
      end
      if (cmd.clr_step) begin
        ptr <= cmd.clr_step && (ptr == LAST_IDX) ? '0 : ptr + IW'(1);
      end else if (cmd.vic_start) begin
        ptr   <= start_next;
        start <= start_next;
        cnt   <= '0;
        dv    <= 1'b0;
      end else if (cmd.pass2_start) begin
        ptr <= start;
        cnt <= '0;
        dv  <= 1'b0;
      end else if (cmd.scan_step) begin
        ptr <= ptr_inc;
        dv  <= 1'b1;
        if (dv) begin
          cnt <= cnt + NW'(1);
        end
      end
      if (cmd.finish) begin
        hand <= vic_inc;
      end
      if (cmd.ref_wr || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_victim) begin
      vic       <= cur;
      vic_dirty <= rd_mod;
    end
    if (cmd.ref_wr) begin
      victim_valid <= 1'b0;
      victim_frame <= '0;
      victim_dirty <= 1'b0;
    end else if (cmd.finish) begin
      victim_valid <= 1'b1;
      victim_frame <= ecvs_pkg::FRAME_W'(vic);
      victim_dirty <= vic_dirty;
    end
  end

  `ECVS_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.ref_wr || cmd.finish, st.out_free, "result lost")
  `ECVS_ASSERT_NEXT(a_hand_in_range, clk, rst, cmd.finish, NW'(hand) < n, "hand out of range")
  `ECVS_ASSERT_NOW(a_clear_on_data, clk, rst, cmd.clear_use, dv, "clear without data")
  `ECVS_ASSERT_NOW(a_victim_use_clear, clk, rst, cmd.latch_victim, dv && !rd_use, "victim in use")

endmodule

`default_nettype wire

[rtl/enhanced_clock_victim_select.sv]
// Clock victim selector. Holds a use bit and a modified bit for each of up to
// MAX_FRAMES physical frames, plus a clock hand. A reference request
// (action 0) marks its frame used, and modified on a write; frames at or above
// the active count are ignored. Every reference yields one result with
// victim_valid low and the other fields zero, posted to the output register
// the cycle after acceptance. A victim request (action 1) first sweeps the
// active frames once from the hand for a frame that is neither used nor
// modified; failing that, it sweeps again from the same start, dropping use
// bits as it passes, and takes the first frame with its use bit clear. The
// victim comes back with its modified bit, both of its bits are cleared and
// the hand moves to the frame after it. The bit memories have a single read
// port, so the scan inspects one frame per clock. The active frame count is
// the clamped frame_count, 1..MAX_FRAMES. After reset the block sweeps all
// MAX_FRAMES entries of both memories to zero and stalls input meanwhile.
// frame_count is written through the cfg channel, which is always ready;
// write it only while no request is in flight.
// ---------------------------------------------------------------------------
// enhanced_clock_victim_select
// Top level: controller and datapath of the second-chance victim selector.
// ---------------------------------------------------------------------------
`default_nettype none

module enhanced_clock_victim_select #(
  parameter int MAX_FRAMES = ecvs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [ecvs_pkg::FRAME_W-1:0]  frame,
  input  wire logic                          is_write,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               victim_valid,
  output logic [ecvs_pkg::FRAME_W-1:0]       victim_frame,
  output logic                               victim_dirty,
  // frame_count write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ecvs_pkg::COUNT_W-1:0]  cfg_data
);

  ecvs_pkg::cmd_t  cmd;
  ecvs_pkg::stat_t st;

  // Register writes never wait; the new count takes effect next cycle
  assign cfg_ready = 1'b1;

  ecvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ecvs_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .frame        (frame),
    .is_write     (is_write),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .victim_valid (victim_valid),
    .victim_frame (victim_frame),
    .victim_dirty (victim_dirty)
  );

endmodule

`default_nettype wire
